// ----- sv/pru_pkg.sv -----
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the pixel replication upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 100;

  localparam int PIX_W   = 24;
  localparam int SCALE_W = 7;
  localparam int SRCW_W  = 11;
  localparam int PAD_W   = 2;
  localparam int ADDR_W  = 3;

  // register indexes on the config port
  localparam logic REG_SCALE        = 1'b0;
  localparam logic REG_SOURCE_WIDTH = 1'b1;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef enum logic [2:0] {
    ST_PIXEL    = 3'd0,
    ST_PAD      = 3'd1,
    ST_LOADED   = 3'd2,
    ST_REJECT   = 3'd3,
    ST_NOTREADY = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       src_done;
  } entry_t;

endpackage

// ----- sv/pru_ram.sv -----
// ----------------------------------------------------------------------------
// pru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pru_front.sv -----
// ----------------------------------------------------------------------------
// pru_front
// Accepts items, classifies them, runs the row/repeat/padding counters and
// owns the line buffer. Each item is registered in stage 1 and pushed into the queue from there.
// ----------------------------------------------------------------------------
module pru_front import pru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [7:0]         in_blue_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_red_in,
  input  logic [SCALE_W-1:0] cfg_scale,
  input  logic [SRCW_W-1:0]  cfg_source_width,
  output logic               q_valid,
  input  logic               q_ready,
  output entry_t             q_entry
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = ((AW > SRCW_W) ? AW : SRCW_W) + 1;

  // effective register values
  logic [SCALE_W-1:0] eff_s;
  logic [SRCW_W-1:0]  eff_w;
  logic [3:0]         ws_prod;
  logic [PAD_W-1:0]   row_bytes;
  logic [PAD_W-1:0]   pad_b;

  always_comb begin
    priority if (cfg_scale == '0) begin
      eff_s = SCALE_W'(1);
    end else if (32'(cfg_scale) > MAX_SCALE) begin
      eff_s = SCALE_W'(MAX_SCALE);
    end else begin
      eff_s = cfg_scale;
    end
    priority if (cfg_source_width == '0) begin
      eff_w = SRCW_W'(1);
    end else if (32'(cfg_source_width) > MAX_WIDTH) begin
      eff_w = SRCW_W'(MAX_WIDTH);
    end else begin
      eff_w = cfg_source_width;
    end
    // bytes per output row mod 4 = (w * s * 3) mod 4
    ws_prod   = eff_w[1:0] * eff_s[1:0];
    row_bytes = PAD_W'(ws_prod[1:0] + {ws_prod[0], 1'b0});
    pad_b     = PAD_W'(2'd0 - row_bytes);
  end

  // control state
  logic [AW-1:0]      load_idx_r, load_idx_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [SCALE_W-1:0] rep_r, rep_nxt;
  logic [SCALE_W-1:0] copy_r, copy_nxt;
  logic [PAD_W-1:0]   padc_r, padc_nxt;
  logic               held_r, held_nxt;
  logic               phase_r, phase_nxt;

  // stage 1 (RAM read in flight)
  logic               s1_v_r, s1_v_nxt;
  status_t            s1_status_r, s1_status_nxt;
  logic               s1_rend_r, s1_rend_nxt;
  logic               s1_done_r, s1_done_nxt;

  logic               advance;
  logic               acc;
  logic               ram_we;
  logic               ram_re;
  logic [PIX_W-1:0]   ram_rdata;

  logic [CW-1:0]      load_inc;
  logic [CW-1:0]      rd_inc;
  logic [SCALE_W:0]   rep_inc;
  logic [SCALE_W:0]   copy_inc;
  logic [PAD_W:0]     padc_inc;

  assign advance  = !s1_v_r || q_ready;
  assign in_ready = advance;
  assign acc      = in_valid && advance;

  assign load_inc = CW'(load_idx_r) + CW'(1);
  assign rd_inc   = CW'(rd_idx_r) + CW'(1);
  assign rep_inc  = {1'b0, rep_r} + (SCALE_W+1)'(1);
  assign copy_inc = {1'b0, copy_r} + (SCALE_W+1)'(1);
  assign padc_inc = {1'b0, padc_r} + (PAD_W+1)'(1);

  always_comb begin
    load_idx_nxt  = load_idx_r;
    rd_idx_nxt    = rd_idx_r;
    rep_nxt       = rep_r;
    copy_nxt      = copy_r;
    padc_nxt      = padc_r;
    held_nxt      = held_r;
    phase_nxt     = phase_r;
    s1_status_nxt = s1_status_r;
    s1_rend_nxt   = s1_rend_r;
    s1_done_nxt   = s1_done_r;
    s1_v_nxt      = advance ? acc : s1_v_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (acc) begin
      s1_rend_nxt = 1'b0;
      s1_done_nxt = 1'b0;
      unique case (in_mode)
        MODE_LOAD: begin
          if (held_r) begin
            s1_status_nxt = ST_REJECT;
          end else begin
            s1_status_nxt = ST_LOADED;
            ram_we        = 1'b1;
            if (load_inc >= CW'(eff_w)) begin
              load_idx_nxt = '0;
              held_nxt     = 1'b1;
              rd_idx_nxt   = '0;
              rep_nxt      = '0;
              padc_nxt     = '0;
              copy_nxt     = '0;
              phase_nxt    = 1'b0;
            end else begin
              load_idx_nxt = AW'(load_inc);
            end
          end
        end
        MODE_PULL: begin
          priority if (!held_r) begin
            s1_status_nxt = ST_NOTREADY;
          end else if (!phase_r) begin
            s1_status_nxt = ST_PIXEL;
            ram_re        = 1'b1;
            if (rep_inc >= {1'b0, eff_s}) begin
              rep_nxt = '0;
              if (rd_inc >= CW'(eff_w)) begin
                rd_idx_nxt = '0;
                if (pad_b == '0) begin
                  s1_rend_nxt = 1'b1;
                end else begin
                  phase_nxt = 1'b1;
                  padc_nxt  = '0;
                end
              end else begin
                rd_idx_nxt = AW'(rd_inc);
              end
            end else begin
              rep_nxt = SCALE_W'(rep_inc);
            end
          end else begin
            s1_status_nxt = ST_PAD;
            if (padc_inc >= {1'b0, pad_b}) begin
              s1_rend_nxt = 1'b1;
            end else begin
              padc_nxt = PAD_W'(padc_inc);
            end
          end
          // end of an output row: rewind, count the replica
          if (s1_rend_nxt) begin
            phase_nxt  = 1'b0;
            padc_nxt   = '0;
            rd_idx_nxt = '0;
            rep_nxt    = '0;
            if (copy_inc >= {1'b0, eff_s}) begin
              copy_nxt    = '0;
              held_nxt    = 1'b0;
              s1_done_nxt = 1'b1;
            end else begin
              copy_nxt = SCALE_W'(copy_inc);
            end
          end
        end
        default: s1_status_nxt = ST_NOTREADY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
      rd_idx_r   <= '0;
      rep_r      <= '0;
      copy_r     <= '0;
      padc_r     <= '0;
      held_r     <= 1'b0;
      phase_r    <= 1'b0;
      s1_v_r     <= 1'b0;
    end else begin
      load_idx_r <= load_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      rep_r      <= rep_nxt;
      copy_r     <= copy_nxt;
      padc_r     <= padc_nxt;
      held_r     <= held_nxt;
      phase_r    <= phase_nxt;
      s1_v_r     <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= s1_status_nxt;
    s1_rend_r   <= s1_rend_nxt;
    s1_done_r   <= s1_done_nxt;
  end

  pru_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(load_idx_r),
    .wdata({in_red_in, in_green_in, in_blue_in}),
    .re   (ram_re),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  // read data stays put while stage 1 stalls (no new read is issued)
  always_comb begin
    q_valid          = s1_v_r;
    q_entry.status   = s1_status_r;
    q_entry.row_end  = s1_rend_r;
    q_entry.src_done = s1_done_r;
    if (s1_status_r == ST_PIXEL) begin
      q_entry.blue  = ram_rdata[7:0];
      q_entry.green = ram_rdata[15:8];
      q_entry.red   = ram_rdata[23:16];
    end else begin
      q_entry.blue  = '0;
      q_entry.green = '0;
      q_entry.red   = '0;
    end
  end

  a_load_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> load_idx_r == '0)
    else $error("load index moved while a row is held");

  a_phase_held: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> held_r)
    else $error("padding phase without a held row");

  a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (rd_idx_r == '0 && rep_r == '0 && copy_r == '0 && padc_r == '0))
    else $error("replay counters not cleared while buffer is free");

  a_done_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_done_r |-> s1_rend_r && !held_r)
    else $error("row done without row end or with row still held");

endmodule

// ----- sv/pru_queue.sv -----
// ----------------------------------------------------------------------------
// pru_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module pru_queue import pru_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int DEPTH = 2;

  entry_t     slot_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("queue count overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == 2'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("push not counted");

endmodule

// ----- sv/pru_back.sv -----
// ----------------------------------------------------------------------------
// pru_back
// Output register: takes results from the queue and holds them for the sink.
// ----------------------------------------------------------------------------
module pru_back import pru_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_valid,
  output logic   q_ready,
  input  entry_t q_entry,
  output logic   out_valid,
  input  logic   out_ready,
  output entry_t out_entry
);

  logic   out_v_r, out_v_nxt;
  entry_t out_e_r;
  logic   load;

  assign q_ready   = !out_v_r || out_ready;
  assign load      = q_valid && q_ready;
  assign out_valid = out_v_r;
  assign out_entry = out_e_r;

  always_comb begin
    out_v_nxt = q_ready ? q_valid : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_e_r <= q_entry;
    end
  end

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(out_e_r))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_e_r.status != ST_PIXEL |->
      (out_e_r.blue == '0 && out_e_r.green == '0 && out_e_r.red == '0))
    else $error("nonzero bytes on a non-pixel result");

  a_done_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_e_r.src_done |-> out_e_r.row_end)
    else $error("row done without row end");

endmodule

// ----- sv/pixel_replication_upscaler_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_replication_upscaler_unit
// Integer nearest-neighbor upscaler: loads one source row into a line buffer, then
// replays it with each pixel and each row repeated scale times, each output row padded to a multiple of 4 bytes.
// ----------------------------------------------------------------------------
// Throughput: one item per clock, loads and pulls alike, as long as out_ready does not stall the output.
// Path: an accepted item passes the stage 1 registers (line buffer read),
//   the two-entry queue and the output register before the sink can take it.
// Reset (rst_n, synchronous): counters cleared, no row held, scale and
//   source_width back to 1. Line buffer contents are not cleared.
module pixel_replication_upscaler_unit import pru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [7:0]        in_blue_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_red_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [7:0]        out_blue_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_red_out,
  output logic              out_row_end,
  output logic              out_source_row_done,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [SCALE_W-1:0] scale_r;
  logic [SRCW_W-1:0]  src_width_r;
  logic               reg_wr;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_W'(1);
      src_width_r <= SRCW_W'(1);
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_SCALE:        scale_r     <= pwdata[SCALE_W-1:0];
        REG_SOURCE_WIDTH: src_width_r <= pwdata[SRCW_W-1:0];
        default:          scale_r     <= scale_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCALE:        prdata = 32'(scale_r);
      REG_SOURCE_WIDTH: prdata = 32'(src_width_r);
      default:          prdata = '0;
    endcase
  end

  logic   fq_valid, fq_ready;
  entry_t fq_entry;
  logic   qb_valid, qb_ready;
  entry_t qb_entry;
  entry_t res;

  pru_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_blue_in      (in_blue_in),
    .in_green_in     (in_green_in),
    .in_red_in       (in_red_in),
    .cfg_scale       (scale_r),
    .cfg_source_width(src_width_r),
    .q_valid         (fq_valid),
    .q_ready         (fq_ready),
    .q_entry         (fq_entry)
  );

  pru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_entry(fq_entry),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_entry (qb_entry)
  );

  pru_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_entry  (qb_entry),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_entry(res)
  );

  assign out_status          = res.status;
  assign out_blue_out        = res.blue;
  assign out_green_out       = res.green;
  assign out_red_out         = res.red;
  assign out_row_end         = res.row_end;
  assign out_source_row_done = res.src_done;

endmodule
